FILE: rtl/wwvb_dst_status_core_macros.svh
// Assertion macros shared by the WWVB DST status core.
`ifndef WWVB_DST_STATUS_CORE_MACROS_SVH
`define WWVB_DST_STATUS_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wds_pkg.sv
// Package with the shared types, constants and calendar functions of the DST status core.
package wds_pkg;

  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned OffsetW = 5;

  localparam logic signed [OffsetW-1:0] OffsetReset = -5'sd5;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthOct = 4'd10;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // Reciprocals for exact constant division of the narrow year terms.
  localparam logic [10:0] Recip25   = 11'd1311;
  localparam int unsigned Recip25Sh = 15;
  localparam logic [13:0] Recip7    = 14'd9363;
  localparam int unsigned Recip7Sh  = 16;

  // Month key of March and November plus the first day of the month.
  localparam logic [12:0] WeekdayBias = 13'd3;

  typedef enum logic [1:0] {
    STATUS_STANDARD  = 2'd0,
    STATUS_ENDS      = 2'd1,
    STATUS_BEGINS    = 2'd2,
    STATUS_IN_EFFECT = 2'd3
  } dst_status_e;

  typedef struct packed {
    logic       leap;
    logic [2:0] first_sunday;
  } year_info_t;

  function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] month,
                                                    input logic leap);
    logic [DayW-1:0] days;
    case (month)
      4'd2:                   days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      default:                days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

FILE: rtl/wds_year_calc.sv
// Leap-year test and first Sunday of March and November for a given year.
module wds_year_calc (
  input  logic [wds_pkg::YearW-1:0] year_i,
  output wds_pkg::year_info_t       info_o
);

  logic [9:0]  year_div4;
  logic [7:0]  year_div16;
  logic [20:0] prod100;
  logic [18:0] prod400;
  logic [5:0]  q100;
  logic [3:0]  q400;
  logic [12:0] rem100;
  logic [12:0] wsum;
  logic [26:0] prod7;
  logic [10:0] q7;
  logic [12:0] wrem;
  logic [2:0]  wday;
  logic        div100;

  assign year_div4  = year_i[11:2];
  assign year_div16 = year_i[11:4];
  assign prod100    = 21'(year_div4) * 21'(wds_pkg::Recip25);
  assign prod400    = 19'(year_div16) * 19'(wds_pkg::Recip25);
  assign q100       = prod100[wds_pkg::Recip25Sh +: 6];
  assign q400       = prod400[wds_pkg::Recip25Sh +: 4];
  assign rem100     = 13'(year_i) - 13'(q100) * 13'd100;
  assign div100     = (rem100 == 13'd0);

  assign wsum  = 13'(year_i) + 13'(year_div4) - 13'(q100) + 13'(q400) + wds_pkg::WeekdayBias;
  assign prod7 = 27'(wsum) * 27'(wds_pkg::Recip7);
  assign q7    = prod7[wds_pkg::Recip7Sh +: 11];
  assign wrem  = wsum - 13'(q7) * 13'd7;
  assign wday  = wrem[2:0];

  always_comb begin
    info_o.leap = ((year_i[1:0] == 2'b00) && !div100) ||
                  (div100 && (year_i[3:0] == 4'b0000));
    if (wday == 3'd0) begin
      info_o.first_sunday = 3'd1;
    end else begin
      info_o.first_sunday = 3'd0 - wday;
    end
  end

endmodule

FILE: rtl/wds_rollback.sv
// Moves the UTC date back one day when the local standard-time hour is negative.
module wds_rollback (
  input  logic [wds_pkg::MonthW-1:0]         month_i,
  input  logic [wds_pkg::DayW-1:0]           day_i,
  input  logic [wds_pkg::HourW-1:0]          hour_i,
  input  logic signed [wds_pkg::OffsetW-1:0] offset_i,
  input  logic                               leap_i,
  output logic [wds_pkg::MonthW-1:0]         month_o,
  output logic [wds_pkg::DayW-1:0]           day_o
);

  logic [6:0]                 hour_sum;
  logic [wds_pkg::MonthW-1:0] prev_month;

  assign hour_sum = {2'b00, hour_i} + {{2{offset_i[wds_pkg::OffsetW-1]}}, offset_i};

  always_comb begin
    if (month_i <= wds_pkg::MonthJan) begin
      prev_month = wds_pkg::MonthDec;
    end else begin
      prev_month = month_i - 4'd1;
    end
  end

  always_comb begin
    month_o = month_i;
    day_o   = day_i;
    if (hour_sum[6]) begin
      if (day_i > 5'd1) begin
        day_o = day_i - 5'd1;
      end else begin
        month_o = prev_month;
        day_o   = wds_pkg::days_in_month(prev_month,
                                         leap_i && (prev_month == wds_pkg::MonthFeb));
      end
    end
  end

endmodule

FILE: rtl/wwvb_dst_status_core.sv
// Top level of the WWVB DST status core: request register, date logic and result register.
// A request is held in the request register; its result and done_o are then registered in
// the result register, from which they drive the ports.
// Throughput: one request per cycle; busy_o is always low and results cannot be stalled.
// Reset clears both pipeline valid flags and sets the zone offset to -5 hours.
// Results leave in request order, one result per request.
module wwvb_dst_status_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [wds_pkg::YearW-1:0]          utc_year_i,
  input  logic [wds_pkg::MonthW-1:0]         utc_month_i,
  input  logic [wds_pkg::DayW-1:0]           utc_day_i,
  input  logic [wds_pkg::HourW-1:0]          utc_hour_i,
  input  logic                               zone_offset_we_i,
  input  logic signed [wds_pkg::OffsetW-1:0] zone_offset_i,
  output logic                               done_o,
  output logic [1:0]                         dst_status_o
);

  `include "wwvb_dst_status_core_macros.svh"

  logic                               req_valid_q;
  logic [wds_pkg::YearW-1:0]          year_q;
  logic [wds_pkg::MonthW-1:0]         month_q;
  logic [wds_pkg::DayW-1:0]           day_q;
  logic [wds_pkg::HourW-1:0]          hour_q;
  logic signed [wds_pkg::OffsetW-1:0] offset_q;
  logic                               done_q;
  wds_pkg::dst_status_e               status_d;
  wds_pkg::dst_status_e               status_q;
  wds_pkg::year_info_t                year_info;
  logic [wds_pkg::MonthW-1:0]         loc_month;
  logic [wds_pkg::DayW-1:0]           loc_day;
  logic [wds_pkg::DayW-1:0]           start_day;
  logic [wds_pkg::DayW-1:0]           end_day;
  logic                               req_accept;

  assign busy_o     = 1'b0;
  assign req_accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= wds_pkg::OffsetReset;
    end else if (zone_offset_we_i) begin
      offset_q <= zone_offset_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      req_valid_q <= req_accept;
      done_q      <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      year_q  <= utc_year_i;
      month_q <= utc_month_i;
      day_q   <= utc_day_i;
      hour_q  <= utc_hour_i;
    end
    if (req_valid_q) begin
      status_q <= status_d;
    end
  end

  wds_year_calc u_year_calc (
    .year_i (year_q),
    .info_o (year_info)
  );

  wds_rollback u_rollback (
    .month_i  (month_q),
    .day_i    (day_q),
    .hour_i   (hour_q),
    .offset_i (offset_q),
    .leap_i   (year_info.leap),
    .month_o  (loc_month),
    .day_o    (loc_day)
  );

  // A step back into another year always lands in December, so the transition
  // months only ever see the request's own year.
  assign end_day   = {2'b00, year_info.first_sunday};
  assign start_day = end_day + 5'd7;

  always_comb begin
    status_d = wds_pkg::STATUS_STANDARD;
    if (loc_month == wds_pkg::MonthMar) begin
      if (loc_day == start_day) begin
        status_d = wds_pkg::STATUS_BEGINS;
      end else if (loc_day > start_day) begin
        status_d = wds_pkg::STATUS_IN_EFFECT;
      end
    end else if (loc_month == wds_pkg::MonthNov) begin
      if (loc_day == end_day) begin
        status_d = wds_pkg::STATUS_ENDS;
      end else if (loc_day < end_day) begin
        status_d = wds_pkg::STATUS_IN_EFFECT;
      end
    end else if (loc_month inside {[wds_pkg::MonthApr:wds_pkg::MonthOct]}) begin
      status_d = wds_pkg::STATUS_IN_EFFECT;
    end
  end

  assign done_o       = done_q;
  assign dst_status_o = status_q;

  `WDS_ASSERT_NEXT(a_req_enters, req_accept, req_valid_q, "accepted request not registered")
  `WDS_ASSERT_NEXT(a_req_done, req_valid_q, done_o, "registered request gave no result")
  `WDS_ASSERT_NOW(a_done_origin, done_o, $past(req_valid_q), "result without a request")
  `WDS_ASSERT_NEXT(a_begins_march, req_valid_q && (loc_month != wds_pkg::MonthMar), dst_status_o != wds_pkg::STATUS_BEGINS, "begins code outside March")

endmodule

FILE: test/tb_wwvb_dst_status_core.sv
// Self-checking testbench for the WWVB DST status core: directed table, random requests, offset sweep.
module tb_wwvb_dst_status_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned PhaseRequests = 210;
  localparam int unsigned OffsetPhases  = 7;
  localparam int unsigned DirectedRows  = 25;
  // March and November share the same month key in the weekday formula.
  localparam int MarNovKey = 2;

  typedef struct packed {
    logic [wds_pkg::YearW-1:0]  year;
    logic [wds_pkg::MonthW-1:0] month;
    logic [wds_pkg::DayW-1:0]   day;
    logic [wds_pkg::HourW-1:0]  hour;
  } date_req_t;

  typedef struct packed {
    date_req_t            req;
    logic                 known;
    wds_pkg::dst_status_e status;
  } directed_row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start_i;
  logic                               busy_o;
  logic [wds_pkg::YearW-1:0]          utc_year_i;
  logic [wds_pkg::MonthW-1:0]         utc_month_i;
  logic [wds_pkg::DayW-1:0]           utc_day_i;
  logic [wds_pkg::HourW-1:0]          utc_hour_i;
  logic                               zone_offset_we_i;
  logic signed [wds_pkg::OffsetW-1:0] zone_offset_i;
  logic                               done_o;
  logic [1:0]                         dst_status_o;

  wds_pkg::dst_status_e               status_queue [$];
  logic signed [wds_pkg::OffsetW-1:0] zone_offset;
  int unsigned                        mismatch_count;
  int unsigned                        checked_count;
  int unsigned                        request_count;
  int unsigned                        offsets_used;
  int unsigned                        cycle_count;
  int unsigned                        status_tally [4];

  directed_row_t directed_rows [DirectedRows] = '{
    '{'{12'd2024, 4'd3,  5'd10, 5'd12}, 1'b1, wds_pkg::STATUS_BEGINS},
    '{'{12'd2024, 4'd3,  5'd10, 5'd2},  1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd2024, 4'd3,  5'd11, 5'd3},  1'b1, wds_pkg::STATUS_BEGINS},
    '{'{12'd2024, 4'd11, 5'd3,  5'd12}, 1'b1, wds_pkg::STATUS_ENDS},
    '{'{12'd2024, 4'd11, 5'd3,  5'd3},  1'b1, wds_pkg::STATUS_IN_EFFECT},
    '{'{12'd2024, 4'd11, 5'd4,  5'd4},  1'b1, wds_pkg::STATUS_ENDS},
    '{'{12'd2024, 4'd7,  5'd15, 5'd12}, 1'b1, wds_pkg::STATUS_IN_EFFECT},
    '{'{12'd2024, 4'd12, 5'd25, 5'd12}, 1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd0,    4'd1,  5'd1,  5'd0},  1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd0,    4'd3,  5'd14, 5'd12}, 1'b0, wds_pkg::STATUS_STANDARD},
    '{'{12'd4095, 4'd15, 5'd31, 5'd31}, 1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd2024, 4'd0,  5'd15, 5'd12}, 1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd2024, 4'd0,  5'd0,  5'd0},  1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd2024, 4'd4,  5'd0,  5'd0},  1'b1, wds_pkg::STATUS_IN_EFFECT},
    '{'{12'd2024, 4'd4,  5'd0,  5'd23}, 1'b1, wds_pkg::STATUS_IN_EFFECT},
    '{'{12'd2024, 4'd3,  5'd0,  5'd23}, 1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd2024, 4'd12, 5'd1,  5'd0},  1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd2024, 4'd11, 5'd1,  5'd0},  1'b1, wds_pkg::STATUS_IN_EFFECT},
    '{'{12'd2024, 4'd3,  5'd1,  5'd0},  1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd2023, 4'd13, 5'd0,  5'd0},  1'b1, wds_pkg::STATUS_STANDARD},
    '{'{12'd2024, 4'd3,  5'd31, 5'd31}, 1'b1, wds_pkg::STATUS_IN_EFFECT},
    '{'{12'd4095, 4'd3,  5'd31, 5'd0},  1'b0, wds_pkg::STATUS_STANDARD},
    '{'{12'd2100, 4'd3,  5'd1,  5'd4},  1'b0, wds_pkg::STATUS_STANDARD},
    '{'{12'd2000, 4'd11, 5'd0,  5'd0},  1'b0, wds_pkg::STATUS_STANDARD},
    '{'{12'd1970, 4'd1,  5'd1,  5'd0},  1'b1, wds_pkg::STATUS_STANDARD}
  };

  wwvb_dst_status_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .utc_year_i       (utc_year_i),
    .utc_month_i      (utc_month_i),
    .utc_day_i        (utc_day_i),
    .utc_hour_i       (utc_hour_i),
    .zone_offset_we_i (zone_offset_we_i),
    .zone_offset_i    (zone_offset_i),
    .done_o           (done_o),
    .dst_status_o     (dst_status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit is_leap_year(input int yr);
    if (yr < 0) return 1'b0;
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int days_of_month(input int mon, input int yr);
    case (mon)
      int'(wds_pkg::MonthFeb): return is_leap_year(yr) ? 29 : 28;
      4, 6, 9, 11:             return 30;
      default:                 return 31;
    endcase
  endfunction

  function automatic int first_sunday_mar_nov(input int yr);
    int wd;
    wd = (yr + yr / 4 - yr / 100 + yr / 400 + MarNovKey + 1) % 7;
    return 1 + ((7 - wd) % 7);
  endfunction

  function automatic wds_pkg::dst_status_e predict_dst_status(
      input date_req_t r, input logic signed [wds_pkg::OffsetW-1:0] ofs);
    int yr;
    int mon;
    int dy;
    int hr;
    int sunday;
    yr  = r.year;
    mon = r.month;
    dy  = r.day;
    hr  = int'(r.hour) + int'(ofs);
    if (hr < 0) begin
      dy--;
      if (dy < 1) begin
        mon--;
        if (mon < int'(wds_pkg::MonthJan)) begin
          mon = int'(wds_pkg::MonthDec);
          yr--;
        end
        dy = days_of_month(mon, yr);
      end
    end
    if (mon == int'(wds_pkg::MonthMar)) begin
      sunday = first_sunday_mar_nov(yr) + 7;
      if (dy == sunday) return wds_pkg::STATUS_BEGINS;
      return (dy > sunday) ? wds_pkg::STATUS_IN_EFFECT : wds_pkg::STATUS_STANDARD;
    end
    if (mon == int'(wds_pkg::MonthNov)) begin
      sunday = first_sunday_mar_nov(yr);
      if (dy == sunday) return wds_pkg::STATUS_ENDS;
      return (dy < sunday) ? wds_pkg::STATUS_IN_EFFECT : wds_pkg::STATUS_STANDARD;
    end
    if (mon >= int'(wds_pkg::MonthApr) && mon <= int'(wds_pkg::MonthOct)) begin
      return wds_pkg::STATUS_IN_EFFECT;
    end
    return wds_pkg::STATUS_STANDARD;
  endfunction

  function automatic date_req_t random_request();
    date_req_t   r;
    int unsigned pick;
    pick   = $urandom_range(99);
    r.year = wds_pkg::YearW'($urandom_range(2399, 1970));
    r.hour = wds_pkg::HourW'($urandom_range(23));
    if (pick < 35) begin
      r.month = $urandom_range(1) ? wds_pkg::MonthMar : wds_pkg::MonthNov;
      r.day   = wds_pkg::DayW'($urandom_range(15, 1));
    end else if (pick < 80) begin
      r.month = wds_pkg::MonthW'($urandom_range(12, 1));
      r.day   = wds_pkg::DayW'($urandom_range(days_of_month(r.month, r.year), 1));
    end else if (pick < 88) begin
      r.month = wds_pkg::MonthW'($urandom_range(12, 1));
      r.day   = wds_pkg::DayW'($urandom_range(1));
      r.hour  = wds_pkg::HourW'($urandom_range(15));
    end else begin
      r.year  = wds_pkg::YearW'($urandom);
      r.month = wds_pkg::MonthW'($urandom);
      r.day   = wds_pkg::DayW'($urandom);
      r.hour  = wds_pkg::HourW'($urandom);
    end
    return r;
  endfunction

  task automatic send_request(input date_req_t r, input wds_pkg::dst_status_e status,
                              input bit steady);
    while (!steady && $urandom_range(99) < 9) begin
      start_i     <= 1'b0;
      utc_year_i  <= wds_pkg::YearW'($urandom);
      utc_month_i <= wds_pkg::MonthW'($urandom);
      utc_day_i   <= wds_pkg::DayW'($urandom);
      utc_hour_i  <= wds_pkg::HourW'($urandom);
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    utc_year_i  <= r.year;
    utc_month_i <= r.month;
    utc_day_i   <= r.day;
    utc_hour_i  <= r.hour;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    status_queue.push_back(status);
    status_tally[status]++;
    request_count++;
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_zone_offset(input logic signed [wds_pkg::OffsetW-1:0] value);
    drain_results();
    zone_offset_we_i <= 1'b1;
    zone_offset_i    <= value;
    @(posedge clk_i);
    zone_offset_we_i <= 1'b0;
    zone_offset      = value;
    offsets_used++;
  endtask

  always @(posedge clk_i) begin
    wds_pkg::dst_status_e want;
    if (rst_ni && done_o) begin
      if (status_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("Unexpected result at cycle %0d: dst_status %0d", cycle_count, dst_status_o);
        end
      end else begin
        want = status_queue.pop_front();
        checked_count++;
        if (dst_status_o !== want) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("Mismatch at cycle %0d: dst_status expected %0d (%s), got %0d",
                     cycle_count, want, want.name(), dst_status_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, status_queue.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [wds_pkg::OffsetW-1:0] phase_offsets [OffsetPhases];
    directed_row_t                      row;
    date_req_t                          r;
    wds_pkg::dst_status_e               status;

    phase_offsets    = '{5'sb10000, 5'sd15, -5'sd12, 5'sd0, -5'sd1, -5'sd8, -5'sd3};
    zone_offset      = wds_pkg::OffsetReset;
    mismatch_count   = 0;
    checked_count    = 0;
    request_count    = 0;
    offsets_used     = 1;
    cycle_count      = 0;
    status_tally     = '{0, 0, 0, 0};
    rst_ni           <= 1'b0;
    start_i          <= 1'b0;
    utc_year_i       <= '0;
    utc_month_i      <= '0;
    utc_day_i        <= '0;
    utc_hour_i       <= '0;
    zone_offset_we_i <= 1'b0;
    zone_offset_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedRows; i++) begin
      row    = directed_rows[i];
      status = row.known ? row.status : predict_dst_status(row.req, zone_offset);
      send_request(row.req, status, 1'b0);
    end
    for (int i = 0; i < PhaseRequests; i++) begin
      r = random_request();
      send_request(r, predict_dst_status(r, zone_offset), 1'b0);
    end

    for (int p = 0; p < OffsetPhases; p++) begin
      if (p == OffsetPhases - 1) phase_offsets[p] = wds_pkg::OffsetW'($urandom);
      write_zone_offset(phase_offsets[p]);
      for (int i = 0; i < PhaseRequests; i++) begin
        r = random_request();
        send_request(r, predict_dst_status(r, zone_offset), p == 2);
      end
    end
    drain_results();

    $display("Checked %0d of %0d requests across %0d zone offset settings, extremes included.",
             checked_count, request_count, offsets_used);
    $display("Expected mix: %0d begins, %0d ends, %0d in effect, %0d standard; %0d mismatches.",
             status_tally[wds_pkg::STATUS_BEGINS], status_tally[wds_pkg::STATUS_ENDS],
             status_tally[wds_pkg::STATUS_IN_EFFECT], status_tally[wds_pkg::STATUS_STANDARD],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
